@@ rtl/cei_pkg.sv @@
// ----------------------------------------------------------------------------
// Color easing interpolator package
// Shared constants, register indexes, mode codes and the sine table builder.
// ----------------------------------------------------------------------------
package cei_pkg;

  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned PROGRESS_BITS_DEF   = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE  = 2'd2;

  localparam logic [2:0] MODE_LINEAR      = 3'd0;
  localparam logic [2:0] MODE_SINE_INOUT  = 3'd1;
  localparam logic [2:0] MODE_SINE_IN     = 3'd2;
  localparam logic [2:0] MODE_SINE_OUT    = 3'd3;
  localparam logic [2:0] MODE_SINE_BOUNCE = 3'd4;
  localparam logic [2:0] MODE_CIRCULAR    = 3'd5;

  // How the eased weight is formed from the sine value, and its binary point.
  typedef enum logic [1:0] {
    KIND_LIN,
    KIND_HALF,
    KIND_IN,
    KIND_RAW
  } kind_e;

  localparam logic [63:0] HALF_PI_Q40 = 64'h3243F6A8885A308D >> 21;

  // Quarter-wave sine entry in Q1.15, from a Q30 Taylor series through x^19.
  function automatic logic [15:0] sine_raw(input int unsigned idx,
                                           input int unsigned tab_bits);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic        [63:0] r;
    logic signed [63:0] sum;
    int unsigned        k;
    x    = ((64'(idx) * HALF_PI_Q40) >> tab_bits) >> 10;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (k = 1; k <= 9; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    r = ($unsigned(sum) + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return r[15:0];
  endfunction

endpackage

@@ rtl/cei_sine_rom.sv @@
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Constant Q1.15 table, forced non-decreasing, read at two addresses per
// cycle while enabled, with registered outputs.
// ----------------------------------------------------------------------------
module cei_sine_rom import cei_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [SINE_TABLE_BITS:0] lo_addr_i,
  input  logic [SINE_TABLE_BITS:0] hi_addr_i,
  output logic [15:0]              lo_o,
  output logic [15:0]              hi_o
);

  localparam int unsigned TabN = 1 << SINE_TABLE_BITS;

  logic [15:0] tab [TabN+1];
  logic [15:0] lo_q;
  logic [15:0] hi_q;

  assign tab[0] = sine_raw(0, SINE_TABLE_BITS);

  for (genvar gi = 1; gi <= TabN; gi++) begin : g_tab
    localparam logic [15:0] Raw = sine_raw(gi, SINE_TABLE_BITS);
    assign tab[gi] = (Raw > tab[gi-1]) ? Raw : tab[gi-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= tab[lo_addr_i];
      hi_q <= tab[hi_addr_i];
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

@@ rtl/color_easing_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// Color easing interpolator
// Blends a packed RGBA start color into an end color along a selectable
// easing curve, one progress word in, one RGBA word out.
// Throughput: one word per cycle when not stalled; five register stages, each with a valid bit.
// The input is ready whenever the output register is free or a stage is empty.
// Reset clears all valid bits and the color and mode registers to zero.
// The sine table is constant logic and needs no clearing after reset.
// ----------------------------------------------------------------------------
module color_easing_interpolator_top import cei_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int unsigned PROGRESS_BITS   = PROGRESS_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                 cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: progress.
  input  logic [((PROGRESS_BITS+8)/8)*8-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // Fields from bit 0: red_out, green_out, blue_out, alpha_out.
  output logic [31:0]                           m_axis_tdata
);

  localparam int unsigned PB   = PROGRESS_BITS;
  localparam int unsigned SB   = SINE_TABLE_BITS;
  localparam int unsigned PH   = PB + 2;
  localparam int unsigned FB   = (PB >= SB) ? PB - SB : 0;
  localparam int unsigned FW   = (FB > 0) ? FB : 1;
  localparam int unsigned Up   = (SB > PB) ? SB - PB : 0;
  localparam int unsigned WW   = (PB + 2 > 18) ? PB + 2 : 18;
  localparam int unsigned PW   = WW + 9;
  localparam int unsigned TW   = PW + 1;

  localparam logic [PB:0]     OneP     = (PB+1)'(1) << PB;
  localparam logic [PH-1:0]   Back     = PH'(3) << PB;
  localparam logic [FW-1:0]   FracMask = (FB > 0) ? {FW{1'b1}} : '0;
  localparam logic signed [WW-1:0] HalfOne = WW'(32768);

  // Configuration registers.
  logic [31:0] start_q;
  logic [31:0] end_q;
  logic [2:0]  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      mode_q  <= MODE_LINEAR;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START_COLOR: start_q <= cfg_wdata_i[31:0];
        REG_END_COLOR:   end_q   <= cfg_wdata_i[31:0];
        REG_CURVE_MODE:  mode_q  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Stage handshake chain.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || m_axis_tready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: saturate progress, form phase and fold it into a quarter turn.
  logic [PB:0]   p_in;
  logic [PB:0]   p_sat;
  logic [PH-1:0] p_ph;
  logic [PH-1:0] phase;
  logic [PB:0]   q_ext;
  logic [PB:0]   qq_d;
  kind_e         kind_d;

  logic [PB:0]   p1_q;
  logic [PB:0]   qq1_q;
  logic          neg1_q;
  kind_e         kind1_q;

  always_comb begin
    p_in  = s_axis_tdata[PB:0];
    p_sat = (p_in > OneP) ? OneP : p_in;
    p_ph  = PH'(p_sat);
    case (mode_q)
      MODE_SINE_INOUT: begin
        phase  = (p_ph << 1) + Back;
        kind_d = KIND_HALF;
      end
      MODE_SINE_IN: begin
        phase  = p_ph + Back;
        kind_d = KIND_IN;
      end
      MODE_SINE_OUT: begin
        phase  = p_ph;
        kind_d = KIND_RAW;
      end
      MODE_SINE_BOUNCE: begin
        phase  = (p_ph << 2) + Back;
        kind_d = KIND_HALF;
      end
      MODE_CIRCULAR: begin
        phase  = (p_ph << 1) + Back;
        kind_d = KIND_RAW;
      end
      default: begin
        phase  = '0;
        kind_d = KIND_LIN;
      end
    endcase
    q_ext = {1'b0, phase[PB-1:0]};
    qq_d  = phase[PB] ? (OneP - q_ext) : q_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p1_q    <= p_sat;
      qq1_q   <= qq_d;
      neg1_q  <= phase[PB+1];
      kind1_q <= kind_d;
    end
  end

  // Stage 2: table index and fraction, table read.
  logic [PB+Up:0] qq_sh;
  logic [SB:0]    idx;
  logic [SB:0]    hi_addr;
  logic [FW-1:0]  frac_d;
  logic [15:0]    lo2;
  logic [15:0]    hi2;

  logic [PB:0]    p2_q;
  logic [FW-1:0]  frac2_q;
  logic           neg2_q;
  kind_e          kind2_q;

  always_comb begin
    qq_sh   = (PB+Up+1)'(qq1_q) << Up;
    idx     = qq_sh[PB+Up:FB];
    hi_addr = idx[SB] ? idx : idx + (SB+1)'(1);
    frac_d  = FW'(qq1_q) & FracMask;
  end

  cei_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk_i    (clk_i),
    .en_i     (en2),
    .lo_addr_i(idx),
    .hi_addr_i(hi_addr),
    .lo_o     (lo2),
    .hi_o     (hi2)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      p2_q    <= p1_q;
      frac2_q <= frac_d;
      neg2_q  <= neg1_q;
      kind2_q <= kind1_q;
    end
  end

  // Stage 3: interpolate between entries, apply sign, form the weight.
  logic [15+FW:0]        step_prod;
  logic [15:0]           mag;
  logic signed [16:0]    sine_s;
  logic signed [WW-1:0]  w_d;

  logic signed [WW-1:0]  w3_q;
  kind_e                 kind3_q;

  always_comb begin
    step_prod = (16+FW)'(hi2 - lo2) * (16+FW)'(frac2_q);
    mag       = lo2 + 16'(step_prod >> FB);
    sine_s    = neg2_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    case (kind2_q)
      KIND_LIN:  w_d = $signed(WW'(p2_q));
      KIND_HALF: w_d = WW'(sine_s) + HalfOne;
      KIND_IN:   w_d = WW'(sine_s) + HalfOne;
      default:   w_d = WW'(sine_s);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      w3_q    <= w_d;
      kind3_q <= kind2_q;
    end
  end

  // Stage 4: per-channel difference times weight.
  logic signed [8:0]    diff [4];
  logic signed [PW-1:0] prod_d [4];
  logic signed [PW-1:0] prod_q [4];
  kind_e                kind4_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      diff[c]   = $signed({1'b0, end_q[8*c +: 8]}) - $signed({1'b0, start_q[8*c +: 8]});
      prod_d[c] = PW'(diff[c]) * PW'(w3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[c] <= prod_d[c];
      end
      kind4_q <= kind3_q;
    end
  end

  // Stage 5: add the scaled start value, truncate, saturate.
  logic signed [TW-1:0] total [4];
  logic        [TW-1:0] shifted [4];
  logic        [7:0]    chan_d [4];
  logic        [31:0]   out_q;
  int unsigned          sh;

  always_comb begin
    case (kind4_q)
      KIND_LIN:  sh = PB;
      KIND_HALF: sh = 16;
      default:   sh = 15;
    endcase
    for (int c = 0; c < 4; c++) begin
      total[c]   = $signed(TW'(start_q[8*c +: 8]) << sh) + TW'(prod_q[c]);
      shifted[c] = $unsigned(total[c] >>> sh);
      if (total[c][TW-1]) begin
        chan_d[c] = 8'd0;
      end else if (shifted[c] > TW'(255)) begin
        chan_d[c] = 8'd255;
      end else begin
        chan_d[c] = shifted[c][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_q <= {chan_d[3], chan_d[2], chan_d[1], chan_d[0]};
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ rtl/cei_checker.sv @@
// ----------------------------------------------------------------------------
// Color easing interpolator port checker
// Watches the stream ports of the top level for ordering and timing slips.
// ----------------------------------------------------------------------------
module cei_checker import cei_pkg::*; #(
  parameter int unsigned PROGRESS_BITS = PROGRESS_BITS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [((PROGRESS_BITS+8)/8)*8-1:0] s_axis_tdata,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [31:0]                        m_axis_tdata
);

  logic in_word;

  assign in_word = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

  // A stalled output word holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // An empty output register means every stage can move, so input is ready.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready with an empty output register");

  // Without back-pressure an accepted word reaches the output valid.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_word ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid)
    else $error("accepted word did not reach the output in time");

endmodule

bind color_easing_interpolator_top cei_checker #(
  .PROGRESS_BITS(PROGRESS_BITS)
) u_cei_checker (.*);

@@ sim/color_easing_interpolator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color easing interpolator testbench
// Drives progress words through the stream input and checks every RGBA word
// against a predictor of the easing curves, kept in step with the registers.
// A directed table comes first, then random phases with new register settings.
// ----------------------------------------------------------------------------
module color_easing_interpolator_top_tb import cei_pkg::*; ();

  localparam int unsigned TDATA_W      = ((PROGRESS_BITS_DEF + 8) / 8) * 8;
  localparam int unsigned P_W          = PROGRESS_BITS_DEF + 1;
  localparam int unsigned TAB_N        = 1 << SINE_TABLE_BITS_DEF;
  localparam int unsigned FRAC_BITS    = PROGRESS_BITS_DEF - SINE_TABLE_BITS_DEF;
  localparam longint unsigned P_ONE    = 64'd1 << PROGRESS_BITS_DEF;
  localparam longint unsigned PI_2_Q40 = 64'h3243F6A8885A308D >> 21;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
  localparam logic [2:0]           MODE_ALT_LO = 3'd6;
  localparam logic [2:0]           MODE_ALT_HI = 3'd7;

  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned NUM_PHASES   = 16;
  localparam int unsigned PHASE_WORDS  = 49;
  localparam int unsigned HOLD_PHASE   = 3;
  localparam int unsigned NUM_ROWS     = 38;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_WORD,
    ROW_WORD_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          value;
    logic [P_W-1:0]       progress;
    logic [31:0]          rgba;
  } stim_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;

  logic [15:0]  sine_q15 [0:TAB_N];
  logic [31:0]  ease_start;
  logic [31:0]  ease_end;
  logic [2:0]   ease_mode;
  logic [31:0]  rgba_expected_q [$];
  int unsigned  bad_cnt  = 0;
  bit           calm     = 1'b0;
  bit           hold_req = 1'b0;
  stim_row_t    dir_tab [NUM_ROWS];

  color_easing_interpolator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic void build_sine_q15();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          acc;
    for (int i = 0; i <= TAB_N; i++) begin
      x    = ((longint'(i) * PI_2_Q40) >> SINE_TABLE_BITS_DEF) >> 10;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 9; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      r = (longint'(acc) + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      if (i > 0 && r < longint'(sine_q15[i-1])) begin
        r = longint'(sine_q15[i-1]);
      end
      sine_q15[i] = r[15:0];
    end
  endfunction

  function automatic int quarter_wave(longint unsigned q);
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned lo;
    longint unsigned hi;
    idx  = q >> FRAC_BITS;
    frac = q & ((64'd1 << FRAC_BITS) - 1);
    if (idx >= TAB_N) begin
      return int'(sine_q15[TAB_N]);
    end
    lo = longint'(sine_q15[idx]);
    hi = longint'(sine_q15[idx+1]);
    lo = lo + (((hi - lo) * frac) >> FRAC_BITS);
    return int'(lo);
  endfunction

  function automatic int sine_at(longint unsigned phase);
    longint unsigned ph;
    longint unsigned quad;
    longint unsigned q;
    int              m;
    ph   = phase & ((P_ONE << 2) - 1);
    quad = (ph >> PROGRESS_BITS_DEF) & 3;
    q    = ph & (P_ONE - 1);
    m    = quad[0] ? quarter_wave(P_ONE - q) : quarter_wave(q);
    return quad[1] ? -m : m;
  endfunction

  function automatic logic [31:0] eased_rgba(logic [P_W-1:0] progress);
    longint unsigned p;
    longint unsigned back;
    longint          w;
    longint          a;
    longint          b;
    longint          total;
    int              shift;
    logic [31:0]     rgba;
    p    = longint'(progress);
    back = 3 * P_ONE;
    if (p > P_ONE) begin
      p = P_ONE;
    end
    case (ease_mode)
      MODE_SINE_INOUT: begin
        w     = longint'(sine_at(2 * p + back)) + 32768;
        shift = 16;
      end
      MODE_SINE_IN: begin
        w     = longint'(sine_at(p + back)) + 32768;
        shift = 15;
      end
      MODE_SINE_OUT: begin
        w     = longint'(sine_at(p));
        shift = 15;
      end
      MODE_SINE_BOUNCE: begin
        w     = longint'(sine_at(4 * p + back)) + 32768;
        shift = 16;
      end
      MODE_CIRCULAR: begin
        w     = longint'(sine_at(2 * p + back));
        shift = 15;
      end
      default: begin
        w     = longint'(p);
        shift = PROGRESS_BITS_DEF;
      end
    endcase
    for (int c = 0; c < 4; c++) begin
      a     = longint'(ease_start[8*c +: 8]);
      b     = longint'(ease_end[8*c +: 8]);
      total = a * (64'sd1 <<< shift) + (b - a) * w;
      if (total < 0) begin
        rgba[8*c +: 8] = 8'd0;
      end else if ((total >>> shift) > 255) begin
        rgba[8*c +: 8] = 8'hFF;
      end else begin
        rgba[8*c +: 8] = 8'(total >>> shift);
      end
    end
    return rgba;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return 0;
    end else if (r < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [P_W-1:0] pick_progress();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return P_W'(P_ONE);
      2:       return P_W'($urandom());
      3:       return P_W'(($urandom_range(0, TAB_N) << FRAC_BITS) + $urandom_range(0, 2) - 1);
      default: return P_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    bad_cnt++;
    if (bad_cnt <= 10) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_START_COLOR: ease_start = value;
      REG_END_COLOR:   ease_end   = value;
      REG_CURVE_MODE:  ease_mode  = value[2:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (rgba_expected_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_progress(input logic [P_W-1:0] progress, input int unsigned gap,
                               input bit known, input logic [31:0] rgba);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(progress);
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    rgba_expected_q.push_back(known ? rgba : eased_rgba(progress));
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_color(int unsigned ph, bit is_end);
    logic [31:0] col;
    case (ph % 5)
      0: col = is_end ? 32'hFFFF_FFFF : 32'h0000_0000;
      1: col = is_end ? 32'h0000_0000 : 32'hFFFF_FFFF;
      2: col = $urandom();
      default: begin
        for (int c = 0; c < 4; c++) begin
          case ($urandom_range(0, 2))
            0:       col[8*c +: 8] = 8'h00;
            1:       col[8*c +: 8] = 8'hFF;
            default: col[8*c +: 8] = 8'($urandom());
          endcase
        end
      end
    endcase
    return col;
  endfunction

  always @(posedge clk_i) begin
    logic [31:0] want;
    string       chan [4];
    chan = '{"red_out", "green_out", "blue_out", "alpha_out"};
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rgba_expected_q.size() == 0) begin
        note_mismatch("unexpected word", 32'h0, m_axis_tdata);
      end else begin
        want = rgba_expected_q.pop_front();
        for (int c = 0; c < 4; c++) begin
          if (m_axis_tdata[8*c +: 8] !== want[8*c +: 8]) begin
            note_mismatch(chan[c], 32'(want[8*c +: 8]), 32'(m_axis_tdata[8*c +: 8]));
          end
        end
      end
    end
  end

  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          @(negedge clk_i);
        end
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 3))
          @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [31:0] mode_word;
    ease_start = '0;
    ease_end   = '0;
    ease_mode  = MODE_LINEAR;
    build_sine_q15();
    dir_tab = '{
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd0,      32'h0000_0000},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd65536,  32'h0000_0000},
      '{ROW_REG,  REG_START_COLOR, 32'h0000_0000, 17'd0, 32'h0},
      '{ROW_REG,  REG_END_COLOR,   32'hFFFF_FFFF, 17'd0, 32'h0},
      '{ROW_REG,  REG_CURVE_MODE,  32'(MODE_LINEAR), 17'd0, 32'h0},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd0,      32'h0000_0000},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd65536,  32'hFFFF_FFFF},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd131071, 32'hFFFF_FFFF},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd32768,  32'h7F7F_7F7F},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd1,      32'h0000_0000},
      '{ROW_REG,  REG_START_COLOR, 32'hFFFF_FFFF, 17'd0, 32'h0},
      '{ROW_REG,  REG_END_COLOR,   32'h0000_0000, 17'd0, 32'h0},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd0,      32'hFFFF_FFFF},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd65536,  32'h0000_0000},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd32768,  32'h7F7F_7F7F},
      '{ROW_REG,  REG_CURVE_MODE,  {29'h1FFF_FFFF, MODE_ALT_LO}, 17'd0, 32'h0},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd16384,  32'hBFBF_BFBF},
      '{ROW_REG,  REG_CURVE_MODE,  32'(MODE_ALT_HI), 17'd0, 32'h0},
      '{ROW_WORD_KNOWN, REG_START_COLOR, 32'h0, 17'd49152,  32'h3F3F_3F3F},
      '{ROW_REG,  REG_START_COLOR, 32'h11FF_0080, 17'd0, 32'h0},
      '{ROW_REG,  REG_END_COLOR,   32'hEE00_FF7F, 17'd0, 32'h0},
      '{ROW_REG,  REG_CURVE_MODE,  32'(MODE_SINE_INOUT), 17'd0, 32'h0},
      '{ROW_WORD, REG_START_COLOR, 32'h0, 17'd0,     32'h0},
      '{ROW_WORD, REG_START_COLOR, 32'h0, 17'd32768, 32'h0},
      '{ROW_WORD, REG_START_COLOR, 32'h0, 17'd65536, 32'h0},
      '{ROW_REG,  REG_CURVE_MODE,  32'(MODE_SINE_IN), 17'd0, 32'h0},
      '{ROW_WORD, REG_START_COLOR, 32'h0, 17'd21845, 32'h0},
      '{ROW_REG,  REG_CURVE_MODE,  32'(MODE_SINE_OUT), 17'd0, 32'h0},
      '{ROW_WORD, REG_START_COLOR, 32'h0, 17'd65535, 32'h0},
      '{ROW_REG,  REG_CURVE_MODE,  32'(MODE_SINE_BOUNCE), 17'd0, 32'h0},
      '{ROW_WORD, REG_START_COLOR, 32'h0, 17'd16384, 32'h0},
      '{ROW_WORD, REG_START_COLOR, 32'h0, 17'd32768, 32'h0},
      '{ROW_REG,  REG_START_COLOR, 32'h0000_00FF, 17'd0, 32'h0},
      '{ROW_REG,  REG_END_COLOR,   32'h0000_FF00, 17'd0, 32'h0},
      '{ROW_REG,  REG_CURVE_MODE,  32'(MODE_CIRCULAR), 17'd0, 32'h0},
      '{ROW_WORD, REG_START_COLOR, 32'h0, 17'd0,     32'h0},
      '{ROW_REG,  REG_SPARE,       32'hFFFF_FFFF, 17'd0, 32'h0},
      '{ROW_WORD, REG_START_COLOR, 32'h0, 17'd65536, 32'h0}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_REG) begin
        if (r == 0 || dir_tab[r-1].kind != ROW_REG) begin
          settle_idle();
        end
        write_reg(dir_tab[r].idx, dir_tab[r].value);
        if (r == NUM_ROWS - 1 || dir_tab[r+1].kind != ROW_REG) begin
          cfg_we <= 1'b0;
        end
      end else begin
        send_progress(dir_tab[r].progress, pick_gap(), dir_tab[r].kind == ROW_WORD_KNOWN,
                      dir_tab[r].rgba);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_idle();
      mode_word = {29'($urandom()), 3'(ph % 8)};
      write_reg(REG_START_COLOR, pick_color(ph, 1'b0));
      write_reg(REG_END_COLOR, pick_color(ph, 1'b1));
      write_reg(REG_CURVE_MODE, mode_word);
      if (ph % 6 == 5) begin
        write_reg(REG_SPARE, $urandom());
      end
      cfg_we <= 1'b0;
      calm = (ph % 4 == 1) || (ph == HOLD_PHASE);
      if (ph == HOLD_PHASE) begin
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_progress(pick_progress(), pick_gap(), 1'b0, 32'h0);
      end
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cei_pkg.sv
rtl/cei_sine_rom.sv
rtl/color_easing_interpolator_top.sv
rtl/cei_checker.sv
sim/color_easing_interpolator_top_tb.sv
